/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the pointer chase block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define CSPC_ASSERT_IMP(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and switched off during reset.
`define CSPC_ASSERT_NXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);

`endif

/* rtl/cspc_pkg.sv */
// ----------------------------------------------------------------------------
// cspc_pkg
// Widths, codes and word types of the cyclic shuffle pointer chase block.
// ----------------------------------------------------------------------------
package cspc_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int INDEX_W     = $clog2(MAX_ENTRIES);
    localparam int SIZE_W      = 11;
    localparam int RANDOM_BITS = 30;
    localparam int HOP_W       = 11;
    localparam int OP_W        = 2;

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_SEL_BIT = 2;

    localparam logic [OP_W-1:0] OP_START   = 2'd0;
    localparam logic [OP_W-1:0] OP_SHUFFLE = 2'd1;
    localparam logic [OP_W-1:0] OP_CHASE   = 2'd2;

    localparam logic REG_TABLE_SIZE     = 1'b0;
    localparam logic REG_SHUFFLE_ENABLE = 1'b1;

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET     = SIZE_W'(MAX_ENTRIES);
    localparam logic              SHUFFLE_ENABLE_RESET = 1'b1;
    localparam logic [SIZE_W-1:0] MIN_SIZE             = SIZE_W'(2);

    typedef struct packed {
        logic [OP_W-1:0]        operation;
        logic [RANDOM_BITS-1:0] random_word;
        logic [HOP_W-1:0]       hop_count;
    } cmd_t;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               shuffle_done;
    } rsp_t;

endpackage

/* rtl/cyclic_shuffle_pointer_chase.sv */
// ----------------------------------------------------------------------------
// cyclic_shuffle_pointer_chase
// Link table with a stepwise cyclic shuffle and a pointer chase, run by a
// microcoded sequencer over one single-port-write, registered-read memory.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | word
//  cmd     | in        | cmd_valid / cmd_stall   | cmd_t: operation, random_word, hop_count
//  rsp     | out       | rsp_valid / rsp_stall   | rsp_t: index, shuffle_done
//  apb     | in        | psel, penable, pready   | table_size at 0x0, shuffle_enable at 0x4
//
//  One word is in work at a time; each accepted word gives one response word.
//  Start fills the link table over the clamped table size, one memory write per entry.
//  A shuffle step finds a bit-serial remainder by the position, then does the swap.
//  In a chase each hop waits on a registered memory read.
//  A disabled or finished shuffle gives index 0; an unknown operation the chase index.
//  Reset clears the sequencer, position and chase index; the table needs a start.
//  A stalled response holds in its register while the next word is taken.
// ----------------------------------------------------------------------------
module cyclic_shuffle_pointer_chase
    import cspc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  cmd_t                  cmd,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_t                  rsp
);

    typedef logic [3:0] step_t;

    localparam step_t ST_IDLE       = 4'd0;
    localparam step_t ST_FILL_INIT  = 4'd1;
    localparam step_t ST_FILL       = 4'd2;
    localparam step_t ST_FILL_END   = 4'd3;
    localparam step_t ST_SHUF_CHECK = 4'd4;
    localparam step_t ST_DIV        = 4'd5;
    localparam step_t ST_RD_POS     = 4'd6;
    localparam step_t ST_RD_K       = 4'd7;
    localparam step_t ST_WR_POS     = 4'd8;
    localparam step_t ST_WR_K       = 4'd9;
    localparam step_t ST_CHASE_INIT = 4'd10;
    localparam step_t ST_CHASE_RD   = 4'd11;
    localparam step_t ST_CHASE_LD   = 4'd12;
    localparam step_t ST_EMIT_CHASE = 4'd13;
    localparam step_t ST_EMIT_ZERO  = 4'd14;

    typedef enum logic [3:0] {
        ACT_NOP,
        ACT_ACCEPT,
        ACT_FILL_INIT,
        ACT_FILL,
        ACT_START_DONE,
        ACT_DIV_INIT,
        ACT_DIV_STEP,
        ACT_RD_POS,
        ACT_RD_K,
        ACT_WR_POS,
        ACT_WR_K,
        ACT_CHASE_INIT,
        ACT_CHASE_RD,
        ACT_CHASE_LD
    } act_t;

    typedef enum logic [2:0] {
        JC_NEXT,
        JC_JUMP,
        JC_DISPATCH,
        JC_LOOP,
        JC_FILL_MORE,
        JC_SKIP,
        JC_NO_HOPS,
        JC_EMIT
    } jc_t;

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_K,
        SRC_CHASE
    } src_t;

    typedef struct packed {
        act_t  act;
        jc_t   jc;
        step_t target;
        src_t  src;
    } ctrl_t;

    function automatic ctrl_t ucode(input step_t s);
        ctrl_t w;
        w = '{act: ACT_NOP, jc: JC_NEXT, target: ST_IDLE, src: SRC_ZERO};
        case (s)
            ST_IDLE:       w = '{act: ACT_ACCEPT, jc: JC_DISPATCH, target: ST_IDLE,
                                 src: SRC_ZERO};
            ST_FILL_INIT:  w = '{act: ACT_FILL_INIT, jc: JC_NEXT, target: ST_IDLE,
                                 src: SRC_ZERO};
            ST_FILL:       w = '{act: ACT_FILL, jc: JC_FILL_MORE, target: ST_FILL,
                                 src: SRC_ZERO};
            ST_FILL_END:   w = '{act: ACT_START_DONE, jc: JC_EMIT, target: ST_IDLE,
                                 src: SRC_ZERO};
            ST_SHUF_CHECK: w = '{act: ACT_DIV_INIT, jc: JC_SKIP, target: ST_EMIT_ZERO,
                                 src: SRC_ZERO};
            ST_DIV:        w = '{act: ACT_DIV_STEP, jc: JC_LOOP, target: ST_DIV,
                                 src: SRC_ZERO};
            ST_RD_POS:     w = '{act: ACT_RD_POS, jc: JC_NEXT, target: ST_IDLE,
                                 src: SRC_ZERO};
            ST_RD_K:       w = '{act: ACT_RD_K, jc: JC_NEXT, target: ST_IDLE,
                                 src: SRC_ZERO};
            ST_WR_POS:     w = '{act: ACT_WR_POS, jc: JC_NEXT, target: ST_IDLE,
                                 src: SRC_ZERO};
            ST_WR_K:       w = '{act: ACT_WR_K, jc: JC_EMIT, target: ST_IDLE,
                                 src: SRC_K};
            ST_CHASE_INIT: w = '{act: ACT_CHASE_INIT, jc: JC_NO_HOPS,
                                 target: ST_EMIT_CHASE, src: SRC_ZERO};
            ST_CHASE_RD:   w = '{act: ACT_CHASE_RD, jc: JC_NEXT, target: ST_IDLE,
                                 src: SRC_ZERO};
            ST_CHASE_LD:   w = '{act: ACT_CHASE_LD, jc: JC_LOOP, target: ST_CHASE_RD,
                                 src: SRC_ZERO};
            ST_EMIT_CHASE: w = '{act: ACT_NOP, jc: JC_EMIT, target: ST_IDLE,
                                 src: SRC_CHASE};
            ST_EMIT_ZERO:  w = '{act: ACT_NOP, jc: JC_EMIT, target: ST_IDLE,
                                 src: SRC_ZERO};
            default:       w = '{act: ACT_NOP, jc: JC_JUMP, target: ST_IDLE,
                                 src: SRC_ZERO};
        endcase
        return w;
    endfunction

    logic [INDEX_W-1:0] link_mem [MAX_ENTRIES];

    step_t                  pc_reg, pc_next;
    logic [HOP_W-1:0]       cnt_reg, cnt_next;
    logic [INDEX_W-1:0]     last_reg, last_next;
    logic [INDEX_W-1:0]     pos_reg, pos_next;
    logic [INDEX_W-1:0]     chase_reg, chase_next;
    logic [INDEX_W-1:0]     rem_reg, rem_next;
    logic [RANDOM_BITS-1:0] quo_reg, quo_next;
    logic [RANDOM_BITS-1:0] word_reg, word_next;
    logic [HOP_W-1:0]       hops_reg, hops_next;
    logic [INDEX_W-1:0]     tmp_reg, tmp_next;
    logic [INDEX_W-1:0]     rd_data_reg;
    logic [SIZE_W-1:0]      table_size_reg;
    logic                   shuffle_enable_reg;
    logic                   rsp_valid_reg, rsp_valid_next;
    rsp_t                   rsp_reg, rsp_next;

    ctrl_t              ctrl;
    logic               hold;
    logic               rsp_load;
    logic               fill_last;
    logic [SIZE_W-1:0]  eff_size;
    logic [SIZE_W-1:0]  eff_last;
    logic [INDEX_W:0]   trial;
    logic [INDEX_W:0]   trial_diff;
    logic [INDEX_W-1:0] rd_addr;
    logic               wr_en;
    logic [INDEX_W-1:0] wr_addr;
    logic [INDEX_W-1:0] wr_data;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cmd_stall = (pc_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        case (paddr[REG_SEL_BIT])
            REG_TABLE_SIZE:     prdata = APB_DATA_W'(table_size_reg);
            REG_SHUFFLE_ENABLE: prdata = APB_DATA_W'(shuffle_enable_reg);
            default:            prdata = '0;
        endcase
    end

    always_comb
    begin
        if (table_size_reg < MIN_SIZE)
        begin
            eff_size = MIN_SIZE;
        end
        else if (table_size_reg > SIZE_W'(MAX_ENTRIES))
        begin
            eff_size = SIZE_W'(MAX_ENTRIES);
        end
        else
        begin
            eff_size = table_size_reg;
        end
        eff_last = eff_size - 1'b1;
    end

    assign ctrl       = ucode(pc_reg);
    assign hold       = (ctrl.jc == JC_EMIT) && rsp_valid_reg && rsp_stall;
    assign rsp_load   = (ctrl.jc == JC_EMIT) && !hold;
    assign fill_last  = (cnt_reg[INDEX_W-1:0] == last_reg);
    assign trial      = {rem_reg, quo_reg[RANDOM_BITS-1]};
    assign trial_diff = trial - {1'b0, pos_reg};

    always_comb
    begin
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        pos_next   = pos_reg;
        chase_next = chase_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        word_next  = word_reg;
        hops_next  = hops_reg;
        tmp_next   = tmp_reg;
        rd_addr    = chase_reg;
        wr_en      = 1'b0;
        wr_addr    = pos_reg;
        wr_data    = rd_data_reg;
        case (ctrl.act)
            ACT_ACCEPT:
            begin
                if (cmd_valid)
                begin
                    word_next = cmd.random_word;
                    hops_next = cmd.hop_count;
                end
            end
            ACT_FILL_INIT:
            begin
                last_next = eff_last[INDEX_W-1:0];
                cnt_next  = '0;
            end
            ACT_FILL:
            begin
                wr_en    = 1'b1;
                wr_addr  = cnt_reg[INDEX_W-1:0];
                wr_data  = fill_last ? '0 : cnt_reg[INDEX_W-1:0] + 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            ACT_START_DONE:
            begin
                pos_next   = last_reg;
                chase_next = '0;
            end
            ACT_DIV_INIT:
            begin
                rem_next = '0;
                quo_next = word_reg;
                cnt_next = HOP_W'(RANDOM_BITS);
            end
            ACT_DIV_STEP:
            begin
                if (trial >= {1'b0, pos_reg})
                begin
                    rem_next = trial_diff[INDEX_W-1:0];
                end
                else
                begin
                    rem_next = trial[INDEX_W-1:0];
                end
                quo_next = quo_reg << 1;
                cnt_next = cnt_reg - 1'b1;
            end
            ACT_RD_POS:
            begin
                rd_addr = pos_reg;
            end
            ACT_RD_K:
            begin
                rd_addr  = rem_reg;
                tmp_next = rd_data_reg;
            end
            ACT_WR_POS:
            begin
                wr_en   = 1'b1;
                wr_addr = pos_reg;
                wr_data = rd_data_reg;
            end
            ACT_WR_K:
            begin
                wr_en    = 1'b1;
                wr_addr  = rem_reg;
                wr_data  = tmp_reg;
                pos_next = pos_reg - 1'b1;
            end
            ACT_CHASE_INIT:
            begin
                cnt_next = hops_reg;
            end
            ACT_CHASE_RD:
            begin
                rd_addr = chase_reg;
            end
            ACT_CHASE_LD:
            begin
                chase_next = rd_data_reg;
                cnt_next   = cnt_reg - 1'b1;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_comb
    begin
        case (ctrl.jc)
            JC_NEXT:      pc_next = pc_reg + 1'b1;
            JC_JUMP:      pc_next = ctrl.target;
            JC_DISPATCH:
            begin
                if (cmd_valid)
                begin
                    case (cmd.operation)
                        OP_START:   pc_next = ST_FILL_INIT;
                        OP_SHUFFLE: pc_next = ST_SHUF_CHECK;
                        OP_CHASE:   pc_next = ST_CHASE_INIT;
                        default:    pc_next = ST_EMIT_CHASE;
                    endcase
                end
                else
                begin
                    pc_next = ST_IDLE;
                end
            end
            JC_LOOP:      pc_next = (cnt_reg != HOP_W'(1)) ? ctrl.target : pc_reg + 1'b1;
            JC_FILL_MORE: pc_next = fill_last ? pc_reg + 1'b1 : ctrl.target;
            JC_SKIP:      pc_next = (!shuffle_enable_reg || pos_reg == '0) ?
                                    ctrl.target : pc_reg + 1'b1;
            JC_NO_HOPS:   pc_next = (hops_reg == '0) ? ctrl.target : pc_reg + 1'b1;
            JC_EMIT:      pc_next = hold ? pc_reg : ST_IDLE;
            default:      pc_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        case (ctrl.src)
            SRC_K:     rsp_next.index = rem_reg;
            SRC_CHASE: rsp_next.index = chase_next;
            default:   rsp_next.index = '0;
        endcase
        rsp_next.shuffle_done = (pos_next == '0);
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && rsp_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg             <= ST_IDLE;
            pos_reg            <= '0;
            chase_reg          <= '0;
            rsp_valid_reg      <= 1'b0;
            table_size_reg     <= TABLE_SIZE_RESET;
            shuffle_enable_reg <= SHUFFLE_ENABLE_RESET;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (!hold)
            begin
                pc_reg    <= pc_next;
                pos_reg   <= pos_next;
                chase_reg <= chase_next;
            end
            if (cfg_write && paddr[REG_SEL_BIT] == REG_TABLE_SIZE)
            begin
                table_size_reg <= pwdata[SIZE_W-1:0];
            end
            if (cfg_write && paddr[REG_SEL_BIT] == REG_SHUFFLE_ENABLE)
            begin
                shuffle_enable_reg <= pwdata[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold)
        begin
            cnt_reg  <= cnt_next;
            last_reg <= last_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            word_reg <= word_next;
            hops_reg <= hops_next;
            tmp_reg  <= tmp_next;
        end
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && !hold)
        begin
            link_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= link_mem[rd_addr];
    end

endmodule

/* rtl/cspc_checker.sv */
// ----------------------------------------------------------------------------
// cspc_checker
// Port-level checks of the pointer chase block, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cspc_checker
    import cspc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    input logic cmd_stall,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    `CSPC_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled response word changed")

    `CSPC_ASSERT_NXT(a_one_in_work, cmd_valid && !cmd_stall, cmd_stall, "command taken while another is in work")

    `CSPC_ASSERT_IMP(a_rsp_from_work, $rose(rsp_valid), $past(cmd_stall), "response appeared without a command in work")

    `CSPC_ASSERT_IMP(a_idle_after_reset, !$past(rst_n), !cmd_stall, "command port not open after reset")

endmodule

bind cyclic_shuffle_pointer_chase cspc_checker u_cspc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
